// ===== src/sssd_pkg.sv =====
// ----------------------------------------------------------------------------
// sssd_pkg
// Shared types, constants and tables for the serial seven-segment driver.
// ----------------------------------------------------------------------------
package sssd_pkg;

  localparam int DIGIT_COUNT = 3;
  localparam int DIGITS_USED = (DIGIT_COUNT < 1) ? 1 : ((DIGIT_COUNT > 4) ? 4 : DIGIT_COUNT);

  localparam int MaxValueInt = (DIGITS_USED == 1) ? 9 :
                               (DIGITS_USED == 2) ? 99 :
                               (DIGITS_USED == 3) ? 999 : 9999;
  localparam logic [13:0] MAX_VALUE = 14'(MaxValueInt);

  localparam logic [1:0] LAST_POS   = 2'(DIGITS_USED - 1);
  localparam logic [3:0] LAST_BIT   = 4'hF;
  localparam logic [7:0] ANODE_BASE = 8'h80;
  localparam logic [7:0] RECIP_TEN  = 8'd205;

  typedef struct packed {
    logic [3:0] digit;
    logic [1:0] pos;
    logic       last;
  } digit_beat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // active-low segment pattern, bit 0 shifted first
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0: pat = 8'b0000_0010;
      4'd1: pat = 8'b1001_1111;
      4'd2: pat = 8'b0010_0100;
      4'd3: pat = 8'b0000_1100;
      4'd4: pat = 8'b1001_1000;
      4'd5: pat = 8'b0100_1001;
      4'd6: pat = 8'b0100_0000;
      4'd7: pat = 8'b0001_1111;
      4'd8: pat = 8'b0000_0000;
      4'd9: pat = 8'b0000_1000;
      default: pat = 8'hFF;
    endcase
    return pat;
  endfunction

endpackage

// ===== src/sssd_front.sv =====
// ----------------------------------------------------------------------------
// sssd_front
// Accepts a value, saturates it and splits it into decimal digits, one digit
// per cycle while the queue is not full, units first.
// ----------------------------------------------------------------------------
module sssd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [10:0]    display_value_i,
  input  sssd_pkg::queue_status_t q_status_i,
  output logic                  push_o,
  output sssd_pkg::digit_beat_t push_beat_o
);

  logic        busy_q, busy_d;
  logic [9:0]  value_q, value_d;
  logic [1:0]  idx_q, idx_d;
  logic [9:0]  clamped;
  logic [17:0] product;
  logic [6:0]  quot;
  logic [9:0]  quot_x10;
  logic [9:0]  rem;
  logic        accept;

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;

  always_comb begin
    if (display_value_i[10]) begin
      clamped = 10'd0;
    end else if ({4'b0, display_value_i[9:0]} > sssd_pkg::MAX_VALUE) begin
      clamped = sssd_pkg::MAX_VALUE[9:0];
    end else begin
      clamped = display_value_i[9:0];
    end
  end

  // divide by ten through reciprocal, exact below 1029
  assign product  = {8'b0, value_q} * {10'b0, sssd_pkg::RECIP_TEN};
  assign quot     = product[17:11];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem      = value_q - quot_x10;

  assign push_o            = busy_q && !q_status_i.full;
  assign push_beat_o.digit = rem[3:0];
  assign push_beat_o.pos   = idx_q;
  assign push_beat_o.last  = (idx_q == sssd_pkg::LAST_POS);

  always_comb begin
    busy_d  = busy_q;
    value_d = value_q;
    idx_d   = idx_q;
    if (accept) begin
      busy_d  = 1'b1;
      value_d = clamped;
      idx_d   = 2'd0;
    end else if (push_o) begin
      value_d = {3'b000, quot};
      idx_d   = idx_q + 2'd1;
      if (push_beat_o.last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== src/sssd_queue.sv =====
// ----------------------------------------------------------------------------
// sssd_queue
// Two-entry queue of digit beats between the front and back parts.
// ----------------------------------------------------------------------------
module sssd_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  sssd_pkg::digit_beat_t   push_beat_i,
  input  logic                    pop_i,
  output sssd_pkg::digit_beat_t   pop_beat_o,
  output sssd_pkg::queue_status_t status_o
);

  sssd_pkg::digit_beat_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign pop_beat_o     = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_beat_i;
    end
  end

endmodule

// ===== src/sssd_back.sv =====
// ----------------------------------------------------------------------------
// sssd_back
// Serializes each digit as anode byte then segment byte, one bit per beat.
// ----------------------------------------------------------------------------
module sssd_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sssd_pkg::queue_status_t q_status_i,
  input  sssd_pkg::digit_beat_t   pop_beat_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    serial_bit_o,
  output logic                    byte_select_o,
  output logic [1:0]              digit_position_o,
  output logic                    digit_done_o,
  output logic                    last_o
);

  logic        busy_q, busy_d;
  logic [15:0] shift_q, shift_d;
  logic [3:0]  bit_q, bit_d;
  logic [1:0]  pos_q, pos_d;
  logic        last_q, last_d;
  logic        accept;
  logic        load;
  logic        end_of_digit;

  assign end_of_digit = (bit_q == sssd_pkg::LAST_BIT);
  assign accept       = busy_q && !out_stall_i;
  assign load         = !busy_q || (accept && end_of_digit);
  assign pop_o        = load && !q_status_i.empty;

  assign out_valid_o      = busy_q;
  assign serial_bit_o     = shift_q[0];
  assign byte_select_o    = bit_q[3];
  assign digit_position_o = pos_q;
  assign digit_done_o     = end_of_digit;
  assign last_o           = last_q && end_of_digit;

  always_comb begin
    busy_d  = busy_q;
    shift_d = shift_q;
    bit_d   = bit_q;
    pos_d   = pos_q;
    last_d  = last_q;
    if (load) begin
      busy_d = pop_o;
      if (pop_o) begin
        shift_d = {sssd_pkg::seg_pattern(pop_beat_i.digit),
                   sssd_pkg::ANODE_BASE >> pop_beat_i.pos};
        bit_d   = 4'd0;
        pos_d   = pop_beat_i.pos;
        last_d  = pop_beat_i.last;
      end
    end else if (accept) begin
      shift_d = {1'b0, shift_q[15:1]};
      bit_d   = bit_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bit_q  <= 4'd0;
    end else begin
      busy_q <= busy_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    pos_q   <= pos_d;
    last_q  <= last_d;
  end

endmodule

// ===== src/seven_segment_serial_display_driver.sv =====
// ----------------------------------------------------------------------------
// seven_segment_serial_display_driver
// Serial shift-register driver for a multiplexed seven-segment display.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   display_value_i
//   out      output     out_valid_o / out_stall_i serial_bit_o, byte_select_o,
//                                                 digit_position_o, digit_done_o,
//                                                 last_o
//
// one value gives 16 beats per digit, 48 at three digits; the bit serializer
// emits one beat per cycle while out is unstalled and a digit is queued
// the front splits a value into digits and runs ahead through a
// two-entry queue, so the serializer keeps streaming across values
// reset clears all control state; out stalls hold the current beat
// ----------------------------------------------------------------------------
module seven_segment_serial_display_driver (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [10:0] display_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               serial_bit_o,
  output logic               byte_select_o,
  output logic [1:0]         digit_position_o,
  output logic               digit_done_o,
  output logic               last_o
);

  sssd_pkg::queue_status_t q_status;
  sssd_pkg::digit_beat_t   push_beat;
  sssd_pkg::digit_beat_t   pop_beat;
  logic                    push;
  logic                    pop;

  sssd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .display_value_i (display_value_i),
    .q_status_i      (q_status),
    .push_o          (push),
    .push_beat_o     (push_beat)
  );

  sssd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_beat_i (push_beat),
    .pop_i       (pop),
    .pop_beat_o  (pop_beat),
    .status_o    (q_status)
  );

  sssd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_status_i       (q_status),
    .pop_beat_i       (pop_beat),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .serial_bit_o     (serial_bit_o),
    .byte_select_o    (byte_select_o),
    .digit_position_o (digit_position_o),
    .digit_done_o     (digit_done_o),
    .last_o           (last_o)
  );

endmodule

// ===== tb/tb_seven_segment_serial_display_driver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_segment_serial_display_driver
// Self-checking bench for the serial seven-segment driver. Display values go
// in through a short directed table and then a random stream. A local model
// saturates and splits each value and expands it into the serial beats the
// shift register chain should see. Every output beat is checked field by
// field against that model. Both channels idle and stall at random, with a
// stretch of full rate, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_seven_segment_serial_display_driver;

  localparam int DIGITS       = sssd_pkg::DIGITS_USED;
  localparam int DISPLAY_MAX  = (DIGITS == 1) ? 9 : (DIGITS == 2) ? 99 :
                                (DIGITS == 3) ? 999 : 9999;
  localparam int BITS_PER_DIG = 16;
  localparam int NUM_DIRECTED = 20;
  localparam int NUM_RANDOM   = 260;
  localparam int CALM_LO      = 40;
  localparam int CALM_HI      = 90;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int PAUSE_AT     = 180;
  localparam int DRAIN_CYCLES = 3 * BITS_PER_DIG * DIGITS;
  localparam int IDLE_LIMIT   = 4000;
  localparam int MAX_REPORTS  = 100;

  // active-low segment patterns, digit 0 in the low byte
  localparam logic [9:0][7:0] SEG_LUT = {
    8'h08, 8'h00, 8'h1F, 8'h40, 8'h49, 8'h98, 8'h0C, 8'h24, 8'h9F, 8'h02
  };

  typedef struct packed {
    logic       serial_bit;
    logic       byte_select;
    logic [1:0] position;
    logic       digit_done;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic signed [10:0] value;
    logic               typed;
    logic [15:0]        digits;
  } display_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [10:0] display_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               serial_bit_o;
  logic               byte_select_o;
  logic [1:0]         digit_position_o;
  logic               digit_done_o;
  logic               last_o;

  beat_t expected_beats[$];
  int    values_sent;
  int    beats_seen;
  int    errors;
  int    reports;
  int    clamped_low;
  int    clamped_high;
  bit    hold_done;

  display_row_t directed_rows [NUM_DIRECTED] = '{
    '{11'sd0,    1'b1, 16'h0000},
    '{11'sd1,    1'b0, 16'h0000},
    '{11'sd9,    1'b0, 16'h0000},
    '{11'sd10,   1'b0, 16'h0000},
    '{11'sd99,   1'b0, 16'h0000},
    '{11'sd100,  1'b0, 16'h0000},
    '{11'sd998,  1'b0, 16'h0000},
    '{11'sd999,  1'b1, 16'h0999},
    '{11'sd1000, 1'b1, 16'h0999},
    '{11'sd1023, 1'b1, 16'h0999},
    '{-11'sd1,   1'b1, 16'h0000},
    '{-11'sd16,  1'b1, 16'h0000},
    '{-11'sd8,   1'b1, 16'h0000},
    '{11'sd123,  1'b0, 16'h0000},
    '{11'sd456,  1'b0, 16'h0000},
    '{11'sd789,  1'b0, 16'h0000},
    '{11'sd231,  1'b0, 16'h0000},
    '{11'sd564,  1'b0, 16'h0000},
    '{11'sd897,  1'b0, 16'h0000},
    '{11'sd1010, 1'b1, 16'h0999}
  };

  seven_segment_serial_display_driver dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .display_value_i  (display_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .serial_bit_o     (serial_bit_o),
    .byte_select_o    (byte_select_o),
    .digit_position_o (digit_position_o),
    .digit_done_o     (digit_done_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit calm_stretch();
    return values_sent >= CALM_LO && values_sent < CALM_HI;
  endfunction

  // saturate and split into bcd digits, units in the low nibble
  function automatic logic [15:0] value_to_digits(input logic signed [10:0] value);
    int          clamped;
    logic [15:0] digits;
    if (value < 0) clamped = 0;
    else if (int'(value) > DISPLAY_MAX) clamped = DISPLAY_MAX;
    else clamped = int'(value);
    for (int p = 0; p < 4; p++) begin
      digits[p*4 +: 4] = 4'(clamped % 10);
      clamped = clamped / 10;
    end
    return digits;
  endfunction

  task automatic queue_digit_beats(input logic [15:0] digits);
    logic [15:0] word;
    beat_t       beat;
    for (int p = 0; p < DIGITS; p++) begin
      word = {SEG_LUT[digits[p*4 +: 4]], 8'h80 >> p};
      for (int b = 0; b < BITS_PER_DIG; b++) begin
        beat.serial_bit  = word[b];
        beat.byte_select = (b >= 8);
        beat.position    = 2'(p);
        beat.digit_done  = (b == BITS_PER_DIG - 1);
        beat.last        = (p == DIGITS - 1) && (b == BITS_PER_DIG - 1);
        expected_beats.push_back(beat);
      end
    end
  endtask

  task automatic offer_value(input logic signed [10:0] value, input logic typed,
                             input logic [15:0] digits);
    if (!calm_stretch()) begin
      while ($urandom_range(99) < 33) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i      <= 1'b1;
    display_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    if (value < 0) clamped_low++;
    else if (int'(value) > DISPLAY_MAX) clamped_high++;
    queue_digit_beats(typed ? digits : value_to_digits(value));
    values_sent++;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin : beat_monitor
    beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: unexpected beat, expected none, actual bit %0d pos %0d",
                   $time, serial_bit_o, digit_position_o);
        end
      end else begin
        want = expected_beats.pop_front();
        check_field("serial_bit", want.serial_bit, serial_bit_o);
        check_field("byte_select", want.byte_select, byte_select_o);
        check_field("digit_position", want.position, digit_position_o);
        check_field("digit_done", want.digit_done, digit_done_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  // output side: random stalls, full rate in the calm stretch, one long hold-off
  initial begin
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && values_sent >= HOLD_AT) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      out_stall_i <= calm_stretch() ? 1'b0 : ($urandom_range(99) < 33);
    end
  end

  // cycles with no beat on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: timeout, no beat for %0d cycles", $time, IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic signed [10:0] value;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    display_value_i = '0;
    values_sent     = 0;
    beats_seen      = 0;
    errors          = 0;
    reports         = 0;
    clamped_low     = 0;
    clamped_high    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer_value(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].digits);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (values_sent == PAUSE_AT) begin
        in_valid_i <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk_i);
      end
      case ($urandom_range(9))
        0:       value = -11'sd16 + 11'($urandom_range(15));
        1:       value = 11'sd990 + 11'($urandom_range(33));
        default: value = 11'($urandom_range(1039)) - 11'sd16;
      endcase
      offer_value(value, 1'b0, 16'h0000);
    end

    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d display values (%0d clamped low, %0d clamped high), %0d beats",
             values_sent, clamped_low, clamped_high, beats_seen);
    $display("with random idling, a full-rate stretch, a long output hold-off and a drain pause");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
